// ===== rtl/lex_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lex_pkg: shared types and constants for the expression lexer
// Token kind codes, scan modes, character tests, keyword and punctuation
// tables, and the result item layout.
// ----------------------------------------------------------------------------
package lex_pkg;

	localparam int KW_NUM     = 8;
	localparam int KW_MAXLEN  = 8;
	localparam int PUNCT_NUM  = 12;

	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_NUMBER  = 5'd1;
	localparam logic [4:0] KIND_IDENT   = 5'd2;
	localparam logic [4:0] KIND_KW_BASE = 5'd3;
	localparam logic [4:0] KIND_PUNCT   = 5'd11;
	localparam logic [4:0] KIND_UNKNOWN = 5'd23;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DOT = 8'h2E;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_IDENT
	} lex_mode_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last;
	} lex_result_t;

	// Up to two results per byte, packed from slot 0; vld[1] implies vld[0].
	typedef struct packed {
		logic [1:0]             vld;
		lex_result_t [1:0]      res;
	} lex_push_t;

	localparam logic [3:0] KW_LEN [KW_NUM] = '{
		4'd3, 4'd4, 4'd6, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3
	};

	localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAXLEN] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"s", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "o", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "q", "r", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "o", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [7:0] PUNCT_CHAR [PUNCT_NUM] = '{
		"#", "{", "}", "+", "-", "*", "/", "^", "%", "(", ")", ";"
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		k = KIND_UNKNOWN;
		for (int i = 0; i < PUNCT_NUM; i++) begin
			if (c == PUNCT_CHAR[i]) begin
				k = KIND_PUNCT + 5'(i);
			end
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lex_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lex_in_if: source byte channel
// Valid/ready channel carrying one source byte and the end-of-text mark.
// ----------------------------------------------------------------------------
interface lex_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_text;

	modport source (output valid, output ch, output end_of_text, input ready);
	modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== rtl/lex_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lex_out_if: token channel
// Valid/ready channel carrying one token per item.
// ----------------------------------------------------------------------------
interface lex_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last, input ready);
	modport sink   (input valid, input token_kind, input token_start,
		input token_length, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/lex_kw_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lex_kw_match: keyword recognizer
// Compares the buffered head of an identifier against the keyword table.
// ----------------------------------------------------------------------------
module lex_kw_match
	import lex_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  wire logic [7:0]               kw_buf [KEYWORD_CHARS],
	input  wire logic [POSITION_BITS-1:0] count,
	input  wire logic                     too_long,
	output logic      [4:0]               kind
);

	logic [KW_NUM-1:0] hit;

	always_comb begin
		for (int k = 0; k < KW_NUM; k++) begin
			hit[k] = (count == POSITION_BITS'(KW_LEN[k]))
				&& (int'(KW_LEN[k]) <= KEYWORD_CHARS);
			for (int i = 0; i < KEYWORD_CHARS; i++) begin
				if ((i < int'(KW_LEN[k])) && (kw_buf[i] != KW_TEXT[k][i])) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		kind = KIND_IDENT;
		if (!too_long && (count <= POSITION_BITS'(KEYWORD_CHARS))) begin
			for (int k = KW_NUM - 1; k >= 0; k--) begin
				if (hit[k]) begin
					kind = KIND_KW_BASE + 5'(k);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lex_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lex_scan: scanner state and per-byte token logic
// Holds the scan state, classifies each accepted byte and produces up to
// two result items for it.
// ----------------------------------------------------------------------------
module lex_scan
	import lex_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_text,
	output lex_push_t       push
);

	localparam int KI = $clog2(KEYWORD_CHARS);
	localparam int EW = POSITION_BITS + 16;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	lex_mode_t                  mode_q, mode_d;
	logic                       saw_dot_q;
	logic                       too_long_q;
	logic [POSITION_BITS-1:0]   begin_q;
	logic [POSITION_BITS-1:0]   count_q;
	logic [POSITION_BITS-1:0]   pos_q;
	logic [7:0]                 kw_buf_q [KEYWORD_CHARS];

	logic                       eof;
	logic                       dig, alpha, space;
	logic                       used;
	logic                       flush_now;
	logic                       single;
	logic                       kw_room;
	logic [4:0]                 ident_kind;
	logic [4:0]                 pend_kind;
	logic [EW-1:0]              begin_ext, count_ext, pos_ext;
	logic [POSITION_BITS-1:0]   count_inc, pos_inc;
	lex_result_t                pend_res, second_res;

	lex_kw_match #(
		.POSITION_BITS(POSITION_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_kw_match (
		.kw_buf   (kw_buf_q),
		.count    (count_q),
		.too_long (too_long_q),
		.kind     (ident_kind)
	);

	assign eof     = end_of_text || (ch == CH_NUL);
	assign dig     = is_digit(ch);
	assign alpha   = is_alpha(ch);
	assign space   = is_space(ch);
	assign kw_room = count_q < POSITION_BITS'(KEYWORD_CHARS);

	assign used = ((mode_q == MODE_NUMBER) && (dig || ((ch == CH_DOT) && !saw_dot_q)))
		|| ((mode_q == MODE_IDENT) && (alpha || dig));
	assign flush_now = (mode_q != MODE_IDLE) && (eof || !used);
	assign single    = !eof && !used && !space && !dig && !alpha;

	assign count_inc = (count_q == POS_MAX) ? POS_MAX : count_q + POS_ONE;
	assign pos_inc   = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_ONE;

	assign begin_ext = EW'(begin_q);
	assign count_ext = EW'(count_q);
	assign pos_ext   = EW'(pos_q);

	// Next scan mode
	always_comb begin
		mode_d = mode_q;
		if (eof) begin
			mode_d = MODE_IDLE;
		end else if (!used) begin
			if (dig) begin
				mode_d = MODE_NUMBER;
			end else if (alpha) begin
				mode_d = MODE_IDENT;
			end else begin
				mode_d = MODE_IDLE;
			end
		end
	end

	// Result items for this byte
	always_comb begin
		pend_kind = (mode_q == MODE_NUMBER) ? KIND_NUMBER : ident_kind;

		pend_res.token_kind   = pend_kind;
		pend_res.token_start  = begin_ext[15:0];
		pend_res.token_length = count_ext[15:0];
		pend_res.last         = !(eof || single);

		second_res.token_kind   = eof ? KIND_EOF : punct_kind(ch);
		second_res.token_start  = pos_ext[15:0];
		second_res.token_length = eof ? 16'd0 : 16'd1;
		second_res.last         = 1'b1;

		if (flush_now) begin
			push.res[0] = pend_res;
			push.res[1] = second_res;
			push.vld    = {eof || single, 1'b1};
		end else begin
			push.res[0] = second_res;
			push.res[1] = second_res;
			push.vld    = {1'b0, eof || single};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			saw_dot_q  <= 1'b0;
			too_long_q <= 1'b0;
			begin_q    <= '0;
			count_q    <= '0;
			pos_q      <= '0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			if (eof) begin
				saw_dot_q  <= 1'b0;
				too_long_q <= 1'b0;
				begin_q    <= '0;
				count_q    <= '0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_inc;
				if (used) begin
					count_q <= count_inc;
					if ((mode_q == MODE_NUMBER) && (ch == CH_DOT)) begin
						saw_dot_q <= 1'b1;
					end
					if ((mode_q == MODE_IDENT) && !kw_room) begin
						too_long_q <= 1'b1;
					end
				end else if (dig) begin
					begin_q   <= pos_q;
					count_q   <= POS_ONE;
					saw_dot_q <= 1'b0;
				end else if (alpha) begin
					begin_q    <= pos_q;
					count_q    <= POS_ONE;
					too_long_q <= 1'b0;
				end
			end
		end
	end

	// Keyword buffer holds the first bytes of the current identifier
	always_ff @(posedge clk) begin
		if (in_fire && !eof) begin
			if (used && (mode_q == MODE_IDENT) && kw_room) begin
				kw_buf_q[count_q[KI-1:0]] <= ch;
			end else if (!used && alpha) begin
				kw_buf_q[0] <= ch;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lex_res_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lex_res_fifo: result queue
// Four-entry queue that takes up to two result items per cycle and
// hands out one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module lex_res_fifo
	import lex_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_en,
	input  wire lex_push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output lex_result_t out_res
);

	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	lex_result_t mem_q [4];
	logic [1:0]  wr_n;
	logic        pop;
	logic [1:0]  n_push;

	assign n_push    = push_en ? (2'(push.vld[0]) + 2'(push.vld[1])) : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_res   = mem_q[rd_q];
	assign room      = cnt_q <= 3'd2;
	assign wr_n      = wr_q + 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push;
			cnt_q <= cnt_q + 3'(n_push) - 3'(pop);
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en && push.vld[0]) begin
			mem_q[wr_q] <= push.res[0];
		end
		if (push_en && push.vld[1]) begin
			mem_q[wr_n] <= push.res[1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/expression_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer: streaming tokenizer for a small expression language
// Scans source text one byte per cycle while the token queue has room and emits tokens.
// ----------------------------------------------------------------------------
// Each accepted byte either extends the pending token, is skipped as
// whitespace, starts a number or identifier, or is a one-byte punctuation or
// unknown token. Tokens come out as kind, start offset and length when they
// end; identifiers of up to KEYWORD_CHARS bytes are checked against eight
// keywords. An end-of-text mark or a zero byte flushes the pending token,
// then emits an end-of-file token at the current offset and restarts the
// offset at zero. Offsets and lengths saturate at 2^POSITION_BITS-1 and are
// reported in their low 16 bits. Throughput: one byte per cycle while each
// byte yields at most one token; a byte that both ends a pending token and
// produces a token of its own (or end of file) yields two, and the output
// side drains one token per cycle. A four-entry token queue separates the
// two sides, so the input keeps flowing while the sink stalls until the
// queue has less than two free slots. The last flag marks the final token
// caused by a byte.
// ----------------------------------------------------------------------------
module expression_lexer
	import lex_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lex_in_if.sink     char_in,
	lex_out_if.source  token_out
);

	logic        in_fire;
	logic        room;
	lex_push_t   push;
	lex_result_t out_res;

	// Accept a byte whenever the queue can absorb two more tokens
	assign char_in.ready = room;
	assign in_fire       = char_in.valid && room;

	// Scan state, byte classification and token building
	lex_scan #(
		.POSITION_BITS(POSITION_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.ch          (char_in.ch),
		.end_of_text (char_in.end_of_text),
		.push        (push)
	);

	// Hold finished tokens until the sink takes them
	lex_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (in_fire),
		.push      (push),
		.room      (room),
		.out_valid (token_out.valid),
		.out_ready (token_out.ready),
		.out_res   (out_res)
	);

	assign token_out.token_kind   = out_res.token_kind;
	assign token_out.token_start  = out_res.token_start;
	assign token_out.token_length = out_res.token_length;
	assign token_out.last         = out_res.last;

endmodule
`default_nettype wire
